>>> sv/xavd_pkg.sv
package xavd_pkg;

	localparam int CNT_W = 6;

	localparam logic [1:0] K_DATA = 2'd0;
	localparam logic [1:0] K_DONE = 2'd1;
	localparam logic [1:0] K_ERR  = 2'd2;

	localparam logic [2:0] E_NONE       = 3'd0;
	localparam logic [2:0] E_NOT_QUOTED = 3'd1;
	localparam logic [2:0] E_NO_VALUE   = 3'd2;
	localparam logic [2:0] E_BAD_NUM    = 3'd3;
	localparam logic [2:0] E_TOO_LONG   = 3'd4;

	localparam logic CMD_SINGLE = 1'b0;
	localparam logic CMD_REPLAY = 1'b1;

	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	localparam int NAME_NUM = 5;

	typedef struct packed {
		logic             op;
		logic [1:0]       kind;
		logic [7:0]       ch;
		logic [2:0]       err;
		logic             tail;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] addr;
		logic [7:0]       data;
	} wr_t;

	// names in order: lt, gt, amp, quot, apos
	function automatic logic [2:0] name_len(input logic [2:0] k);
		logic [2:0] len;
		case (k)
			3'd0, 3'd1: len = 3'd2;
			3'd2:       len = 3'd3;
			default:    len = 3'd4;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] name_char(input logic [2:0] k, input logic [1:0] p);
		logic [7:0] c;
		case ({k, p})
			{3'd0, 2'd0}: c = 8'h6C;
			{3'd0, 2'd1}: c = 8'h74;
			{3'd1, 2'd0}: c = 8'h67;
			{3'd1, 2'd1}: c = 8'h74;
			{3'd2, 2'd0}: c = 8'h61;
			{3'd2, 2'd1}: c = 8'h6D;
			{3'd2, 2'd2}: c = 8'h70;
			{3'd3, 2'd0}: c = 8'h71;
			{3'd3, 2'd1}: c = 8'h75;
			{3'd3, 2'd2}: c = 8'h6F;
			{3'd3, 2'd3}: c = 8'h74;
			{3'd4, 2'd0}: c = 8'h61;
			{3'd4, 2'd1}: c = 8'h70;
			{3'd4, 2'd2}: c = 8'h6F;
			{3'd4, 2'd3}: c = 8'h73;
			default:      c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] name_out(input logic [2:0] k);
		logic [7:0] c;
		case (k)
			3'd0:    c = 8'h3C;
			3'd1:    c = 8'h3E;
			3'd2:    c = CH_AMP;
			3'd3:    c = CH_DQUOTE;
			default: c = CH_SQUOTE;
		endcase
		return c;
	endfunction

	// {valid, value}
	function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b1, 4'(b - 8'h30)};
		else if (hex && b >= 8'h61 && b <= 8'h66)
			r = {1'b1, 4'(b - 8'h57)};
		else if (hex && b >= 8'h41 && b <= 8'h46)
			r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

endpackage

>>> sv/xavd_in_if.sv
interface xavd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_value;
	logic       end_of_data;

	modport source (output valid, in_byte, start_value, end_of_data, input ready);
	modport sink (input valid, in_byte, start_value, end_of_data, output ready);
endinterface

>>> sv/xavd_out_if.sv
interface xavd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic       last;

	modport source (output valid, out_kind, out_byte, error_code, last, input ready);
	modport sink (input valid, out_kind, out_byte, error_code, last, output ready);
endinterface

>>> sv/xavd_cmd_fifo.sv
module xavd_cmd_fifo
	import xavd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic cmd_valid,
	output cmd_t cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [QW-1:0] cnt_q;

	assign full      = cnt_q == QW'(DEPTH);
	assign cmd_valid = cnt_q != '0;
	assign cmd       = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("request pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cmd_valid)
		else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QW'(DEPTH))
		else $error("queue fill count out of range");
`endif

endmodule

>>> sv/xavd_front.sv
module xavd_front
	import xavd_pkg::*;
#(
	parameter int ENTITY_MAX = 16
) (
	input  logic clk,
	input  logic arst_n,
	xavd_in_if.sink in_ch,
	input  logic q_full,
	input  logic replay_done,
	output logic push,
	output cmd_t push_cmd,
	output wr_t  wr
);

	localparam int CW = $clog2(ENTITY_MAX + 1);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_VALUE  = 2'd1;
	localparam logic [1:0] PH_ENTITY = 2'd2;

	logic [1:0]          phase_q, phase_d;
	logic [7:0]          quote_q, quote_d;
	logic [CW-1:0]       ecnt_q, ecnt_d;
	logic                ovf_q, ovf_d;
	logic [NAME_NUM-1:0] match_q, match_d;
	logic                hash_q, hash_d;
	logic                hex_q, hex_d;
	logic                stop_q, stop_d;
	logic                dig_q, dig_d;
	logic [7:0]          val_q, val_d;
	logic                pend_q;

	logic       acc;
	logic       has_res;
	cmd_t       res;
	cmd_t       dec;
	logic       hit;
	logic [7:0] hit_ch;
	logic [4:0] dgt;
	logic [7:0] b;

	assign b           = in_ch.in_byte;
	assign in_ch.ready = !q_full && !pend_q;
	assign acc         = in_ch.valid && in_ch.ready;
	assign push        = acc && has_res;
	assign push_cmd    = res;

	// decode of the entity collected so far
	always_comb begin
		hit    = 1'b0;
		hit_ch = 8'h00;
		for (int k = 0; k < NAME_NUM; k++) begin
			if (match_q[k] && ecnt_q == CW'(name_len(3'(k)))) begin
				hit    = 1'b1;
				hit_ch = name_out(3'(k));
			end
		end
		dec      = '0;
		dec.op   = CMD_SINGLE;
		dec.kind = K_DATA;
		dec.err  = E_NONE;
		if (ovf_q) begin
			dec.kind = K_ERR;
			dec.err  = E_TOO_LONG;
		end else if (hit) begin
			dec.ch = hit_ch;
		end else if (hash_q) begin
			if (!dig_q) begin
				dec.kind = K_ERR;
				dec.err  = E_BAD_NUM;
			end else begin
				dec.ch = val_q;
			end
		end else begin
			dec.op  = CMD_REPLAY;
			dec.cnt = CNT_W'(ecnt_q);
		end
	end

	always_comb begin
		phase_d = phase_q;
		quote_d = quote_q;
		ecnt_d  = ecnt_q;
		ovf_d   = ovf_q;
		match_d = match_q;
		hash_d  = hash_q;
		hex_d   = hex_q;
		stop_d  = stop_q;
		dig_d   = dig_q;
		val_d   = val_q;
		has_res = 1'b0;
		res     = '0;
		wr      = '0;
		dgt     = digit_of(b, hex_q);

		if (in_ch.end_of_data) begin
			has_res = 1'b1;
			phase_d = PH_IDLE;
			if (phase_q == PH_VALUE) begin
				res.kind = K_DONE;
			end else if (phase_q == PH_ENTITY) begin
				res      = dec;
				res.tail = 1'b1;
			end else begin
				res.kind = K_ERR;
				res.err  = E_NO_VALUE;
			end
		end else if (in_ch.start_value) begin
			if (b == CH_DQUOTE || b == CH_SQUOTE) begin
				quote_d = b;
				phase_d = PH_VALUE;
			end else begin
				has_res  = 1'b1;
				res.kind = K_ERR;
				res.err  = E_NOT_QUOTED;
				phase_d  = PH_IDLE;
			end
		end else begin
			unique case (phase_q)
				PH_VALUE: begin
					if (b == quote_q) begin
						has_res  = 1'b1;
						res.kind = K_DONE;
						phase_d  = PH_IDLE;
					end else if (b == CH_AMP) begin
						ecnt_d  = '0;
						ovf_d   = 1'b0;
						match_d = '1;
						hash_d  = 1'b0;
						hex_d   = 1'b0;
						stop_d  = 1'b0;
						dig_d   = 1'b0;
						val_d   = 8'h00;
						phase_d = PH_ENTITY;
					end else begin
						has_res  = 1'b1;
						res.kind = K_DATA;
						res.ch   = b;
					end
				end
				PH_ENTITY: begin
					if (b == CH_SEMI) begin
						has_res = 1'b1;
						res     = dec;
						phase_d = PH_VALUE;
					end else if (ecnt_q < CW'(ENTITY_MAX)) begin
						wr.en   = acc;
						wr.addr = CNT_W'(ecnt_q);
						wr.data = b;
						ecnt_d  = ecnt_q + 1'b1;
						for (int k = 0; k < NAME_NUM; k++)
							match_d[k] = match_q[k] && (ecnt_q < CW'(name_len(3'(k))))
								&& b == name_char(3'(k), ecnt_q[1:0]);
						if (ecnt_q == '0) begin
							hash_d = b == CH_HASH;
						end else if (hash_q && !stop_q) begin
							if (ecnt_q == CW'(1) && b == CH_X) begin
								hex_d = 1'b1;
							end else if (!dgt[4]) begin
								stop_d = 1'b1;
							end else begin
								dig_d = 1'b1;
								if (hex_q)
									val_d = {val_q[3:0], dgt[3:0]};
								else
									val_d = (val_q << 3) + (val_q << 1) + {4'h0, dgt[3:0]};
							end
						end
					end else begin
						ovf_d = 1'b1;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			quote_q <= 8'h00;
			ecnt_q  <= '0;
			ovf_q   <= 1'b0;
			match_q <= '0;
			hash_q  <= 1'b0;
			hex_q   <= 1'b0;
			stop_q  <= 1'b0;
			dig_q   <= 1'b0;
			val_q   <= 8'h00;
			pend_q  <= 1'b0;
		end else begin
			if (acc) begin
				phase_q <= phase_d;
				quote_q <= quote_d;
				ecnt_q  <= ecnt_d;
				ovf_q   <= ovf_d;
				match_q <= match_d;
				hash_q  <= hash_d;
				hex_q   <= hex_d;
				stop_q  <= stop_d;
				dig_q   <= dig_d;
				val_q   <= val_d;
			end
			// hold off until the entity buffer has been replayed
			if (push && res.op == CMD_REPLAY)
				pend_q <= 1'b1;
			else if (replay_done)
				pend_q <= 1'b0;
		end
	end

endmodule

>>> sv/xavd_back.sv
module xavd_back
	import xavd_pkg::*;
#(
	parameter int ENTITY_MAX = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	input  wr_t  wr,
	output logic pop,
	output logic replay_done,
	xavd_out_if.source out_ch
);

	localparam int AW = $clog2(ENTITY_MAX);
	localparam int JW = $clog2(ENTITY_MAX + 3);

	logic [7:0]    ent_mem [ENTITY_MAX];
	logic [7:0]    rd_q;
	logic [AW-1:0] ptr_q, ptr_d;

	logic          act_q;
	cmd_t          cur_q;
	logic [JW-1:0] j_q;

	logic          ov_q;
	logic [1:0]    kind_q;
	logic [7:0]    ch_q;
	logic [2:0]    err_q;
	logic          last_q;

	logic          adv;
	logic          fin;
	logic [JW-1:0] body_end;
	logic [1:0]    n_kind;
	logic [7:0]    n_ch;
	logic [2:0]    n_err;
	logic          n_last;

	assign out_ch.valid      = ov_q;
	assign out_ch.out_kind   = kind_q;
	assign out_ch.out_byte   = ch_q;
	assign out_ch.error_code = err_q;
	assign out_ch.last       = last_q;

	assign adv         = act_q && (!ov_q || out_ch.ready);
	assign body_end    = (cur_q.op == CMD_REPLAY) ? JW'(cur_q.cnt) + 1'b1 : '0;
	assign fin         = j_q == body_end + JW'(cur_q.tail);
	assign pop         = cmd_valid && (!act_q || (adv && fin));
	assign replay_done = adv && fin && cur_q.op == CMD_REPLAY;

	// advance the read address so the next stored byte is in rd_q by the next cycle
	assign ptr_d = (adv && j_q < JW'(cur_q.cnt)) ? j_q[AW-1:0] : ptr_q;

	always_comb begin
		n_kind = K_DATA;
		n_ch   = 8'h00;
		n_err  = E_NONE;
		n_last = 1'b0;
		if (j_q > body_end) begin
			n_kind = K_DONE;
			n_last = 1'b1;
		end else if (cur_q.op == CMD_SINGLE) begin
			n_kind = cur_q.kind;
			n_ch   = cur_q.ch;
			n_err  = cur_q.err;
			n_last = !cur_q.tail;
		end else if (j_q == '0) begin
			n_ch = CH_AMP;
		end else if (j_q == body_end) begin
			n_ch   = CH_SEMI;
			n_last = !cur_q.tail;
		end else begin
			n_ch = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en)
			ent_mem[wr.addr[AW-1:0]] <= wr.data;
		rd_q <= ent_mem[ptr_d];
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= cmd;
		if (adv) begin
			kind_q <= n_kind;
			ch_q   <= n_ch;
			err_q  <= n_err;
			last_q <= n_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			j_q   <= '0;
			ptr_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			ptr_q <= ptr_d;
			if (pop) begin
				act_q <= 1'b1;
				j_q   <= '0;
			end else if (adv && fin) begin
				act_q <= 1'b0;
			end else if (adv) begin
				j_q <= j_q + 1'b1;
			end
			if (adv)
				ov_q <= 1'b1;
			else if (out_ch.ready)
				ov_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!act_q || (adv && fin)))
		else $error("request taken while previous one still running");
	a_single_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q && cur_q.op == CMD_SINGLE) |-> (j_q <= JW'(cur_q.tail)))
		else $error("single request ran past its steps");
	a_replay_len: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q && cur_q.op == CMD_REPLAY) |-> (cur_q.cnt <= CNT_W'(ENTITY_MAX)))
		else $error("replay longer than entity buffer");
`endif

endmodule

>>> sv/xml_attribute_value_decoder_core.sv
// XML attribute value decoder.
// in_ch carries one byte of the attribute value per request (with start_value
// marking the opening quote and end_of_data marking the end of the source);
// out_ch carries decoded results: data bytes, value complete, or an error,
// with last set on the final result caused by each input request.
// The front end takes one input request per cycle while in_ch.ready is high,
// tracks the quote and the entity being collected, and queues at most one
// decode request per input. The back end turns each queued request into
// results at one per cycle from its output register while out_ch is not
// stalled. An unknown entity is replayed literally from the entity buffer as
// '&', the stored bytes and ';', and input is held off from the ';' until the
// replay finishes. Otherwise, with no stall, the sustained rate is one byte a cycle.
// When the receiver stalls, the output register holds, the request queue
// fills and in_ch.ready drops. After reset the block awaits an opening quote
// with an empty queue; the entity buffer is not cleared and needs no sweep.
module xml_attribute_value_decoder_core
	import xavd_pkg::*;
#(
	parameter int ENTITY_MAX  = 16,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	xavd_in_if.sink    in_ch,
	xavd_out_if.source out_ch
);

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic cmd_valid;
	cmd_t cmd;
	wr_t  wr;
	logic replay_done;

	xavd_front #(
		.ENTITY_MAX(ENTITY_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.q_full     (q_full),
		.replay_done(replay_done),
		.push       (push),
		.push_cmd   (push_cmd),
		.wr         (wr)
	);

	xavd_cmd_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	xavd_back #(
		.ENTITY_MAX(ENTITY_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.wr         (wr),
		.pop        (pop),
		.replay_done(replay_done),
		.out_ch     (out_ch)
	);

endmodule
